// ===== src/rpa_pkg.sv =====
// Shared types and constants for the reference-counted page allocator.
package rpa_pkg;

    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 39;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 3'd0,
        ACT_FREE  = 3'd1,
        ACT_INC   = 3'd2,
        ACT_DEC   = 3'd3,
        ACT_GET   = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_BADFREE = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ===== src/refcounted_page_allocator.sv =====
// Top level of the reference-counted page allocator.
//
// A transaction is accepted when start is high and busy is low. done is registered out of the
// S_EXEC state that follows and strobes for exactly one cycle with status, page_addr, count and
// page_released, and the result is taken at the edge that ends that cycle. The receiver cannot
// stall, so results must be taken in that cycle. The count RAM and the free-stack RAM are read
// when a transaction is accepted, then modified and written back in S_EXEC; busy is high there,
// so a new transaction is accepted only after the write-back. After reset the block sweeps the
// count RAM to zero, one entry a cycle, holding busy high until the sweep ends. first_owned_page
// may be written through cfg_we/cfg_data whenever no transaction is in flight.
module refcounted_page_allocator #(
    parameter int unsigned NUM_PAGES  = 32768,
    parameter logic [38:0] BASE_ADDR  = 39'd2147483648,
    parameter int unsigned PAGE_BYTES = 4096,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rpa_pkg::ACTION_W-1:0]        action,
    input  logic [rpa_pkg::ADDR_W-1:0]          addr,
    input  logic                                cfg_we,
    input  logic [rpa_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic [rpa_pkg::STATUS_W-1:0]        status,
    output logic [rpa_pkg::ADDR_W-1:0]          page_addr,
    output logic signed [rpa_pkg::COUNT_W-1:0]  count,
    output logic                                page_released
);

    import rpa_pkg::*;

    localparam int PG_W     = $clog2(NUM_PAGES);
    localparam int PG_SHIFT = $clog2(PAGE_BYTES);
    localparam int CMP_W    = (PG_W + 1 > CFG_W) ? PG_W + 1 : CFG_W;
    localparam int EXT_W    = ADDR_W + 2;
    localparam int CB       = COUNT_BITS;
    localparam logic [EXT_W-1:0] BASE_EXT = EXT_W'(BASE_ADDR);
    localparam logic [EXT_W-1:0] MEM_END  = BASE_EXT + (EXT_W'(NUM_PAGES) << PG_SHIFT);
    localparam logic [PG_W-1:0]  LAST_PG  = PG_W'(NUM_PAGES - 1);

    state_t state_reg, state_next;

    logic [PG_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [PG_W:0]     stack_top_reg, stack_top_next;
    logic [PG_W:0]     wm_reg, wm_next;
    logic [CFG_W-1:0]  first_reg;

    logic [ACTION_W-1:0] act_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PG_W-1:0]     pg_reg;
    logic [PG_W-1:0]     pg_in;
    logic [ADDR_W-1:0]   addr_off;

    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0]    page_addr_reg, page_addr_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 released_reg, released_next;

    // count RAM
    logic            cnt_we;
    logic [PG_W-1:0] cnt_waddr;
    logic [CB-1:0]   cnt_wdata;
    logic [CB-1:0]   cnt_rdata;
    logic            ex_cnt_we;
    logic [PG_W-1:0] ex_cnt_waddr;
    logic [CB-1:0]   ex_cnt_wdata;

    // free-stack RAM
    logic            stk_we;
    logic [PG_W-1:0] stk_waddr;
    logic [PG_W-1:0] stk_raddr;
    logic [PG_W-1:0] stk_rdata;

    // execute-stage terms
    logic            in_mem;
    logic            aligned;
    logic            pg_owned;
    logic            stack_nonempty;
    logic            alloc_ok;
    logic [PG_W-1:0] alloc_pg;
    logic [CB-1:0]   dec_val;
    logic [CB-1:0]   inc_val;
    logic            dec_nonpos;
    logic [CB-1:0]   res_cnt;
    logic            res_neg1;
    logic            res_cnt_zero;
    logic [COUNT_W-1:0] res_cnt16;

    assign addr_off  = addr - BASE_ADDR;
    assign pg_in     = PG_W'(addr_off >> PG_SHIFT);
    assign stk_raddr = PG_W'(stack_top_reg - 1'b1);
    assign stk_waddr = PG_W'(stack_top_reg);

    assign in_mem   = ({2'b00, addr_reg} >= BASE_EXT) && ({2'b00, addr_reg} < MEM_END);
    assign aligned  = (addr_reg[PG_SHIFT-1:0] == '0);
    assign pg_owned = (CMP_W'(pg_reg) >= CMP_W'(first_reg));

    assign stack_nonempty = (stack_top_reg != '0);
    assign alloc_ok       = stack_nonempty || (CMP_W'(wm_reg) > CMP_W'(first_reg));
    assign alloc_pg       = stack_nonempty ? stk_rdata : PG_W'(wm_reg - 1'b1);

    assign dec_val    = cnt_rdata - CB'(1);
    assign inc_val    = cnt_rdata + CB'(1);
    assign dec_nonpos = (dec_val == '0) || dec_val[CB-1];

    // low 16 bits of the count, sign-extended when the count is narrower
    generate
        if (CB >= COUNT_W)
        begin : g_cnt_trunc
            assign res_cnt16 = res_cnt[COUNT_W-1:0];
        end
        else
        begin : g_cnt_sext
            assign res_cnt16 = {{(COUNT_W - CB){res_cnt[CB-1]}}, res_cnt};
        end
    endgenerate

    rpa_ram #(
        .WIDTH (CB),
        .DEPTH (NUM_PAGES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (pg_in),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (PG_W),
        .DEPTH (NUM_PAGES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (pg_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // clearing sweep owns the count RAM write port until it finishes
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we    = ex_cnt_we;
            cnt_waddr = ex_cnt_waddr;
            cnt_wdata = ex_cnt_wdata;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_PG)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        busy = (state_reg != S_IDLE);
    end

    // read-modify-write of the current transaction
    always_comb
    begin
        stack_top_next = stack_top_reg;
        wm_next        = wm_reg;
        ex_cnt_we      = 1'b0;
        ex_cnt_waddr   = pg_reg;
        ex_cnt_wdata   = '0;
        stk_we         = 1'b0;
        status_next    = ST_OK;
        page_addr_next = '0;
        res_cnt        = '0;
        res_neg1       = 1'b0;
        res_cnt_zero   = 1'b0;
        released_next  = 1'b0;
        done_next      = 1'b0;

        if (state_reg == S_EXEC)
        begin
            done_next = 1'b1;
            case (act_reg)
                ACT_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        if (stack_nonempty)
                        begin
                            stack_top_next = stack_top_reg - 1'b1;
                        end
                        else
                        begin
                            wm_next = wm_reg - 1'b1;
                        end
                        ex_cnt_we      = 1'b1;
                        ex_cnt_waddr   = alloc_pg;
                        ex_cnt_wdata   = CB'(1);
                        res_cnt        = CB'(1);
                        page_addr_next = BASE_ADDR + (ADDR_W'(alloc_pg) << PG_SHIFT);
                    end
                    else
                    begin
                        status_next = ST_OOM;
                    end
                end
                ACT_FREE:
                begin
                    if (!aligned || !in_mem || !pg_owned)
                    begin
                        status_next = ST_BADFREE;
                    end
                    else
                    begin
                        ex_cnt_we    = 1'b1;
                        ex_cnt_wdata = dec_val;
                        res_cnt      = dec_val;
                        if (dec_nonpos)
                        begin
                            if (stack_top_reg < (PG_W+1)'(NUM_PAGES))
                            begin
                                stk_we         = 1'b1;
                                stack_top_next = stack_top_reg + 1'b1;
                                released_next  = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                    end
                end
                ACT_INC, ACT_DEC, ACT_GET:
                begin
                    if (!in_mem)
                    begin
                        status_next = ST_RANGE;
                        res_neg1    = 1'b1;
                    end
                    else if (act_reg == ACT_INC)
                    begin
                        ex_cnt_we    = 1'b1;
                        ex_cnt_wdata = inc_val;
                        res_cnt      = inc_val;
                    end
                    else if (act_reg == ACT_DEC)
                    begin
                        ex_cnt_we    = 1'b1;
                        ex_cnt_wdata = dec_val;
                        res_cnt      = dec_val;
                    end
                    else
                    begin
                        res_cnt = cnt_rdata;
                    end
                end
                default:
                begin
                    status_next  = ST_RANGE;
                    res_cnt_zero = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (res_neg1)
        begin
            count_next = '1;
        end
        else if (res_cnt_zero)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = res_cnt16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            stack_top_reg <= '0;
            wm_reg        <= (PG_W+1)'(NUM_PAGES);
            first_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            stack_top_reg <= stack_top_next;
            wm_reg        <= wm_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                first_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg  <= action;
            addr_reg <= addr;
            pg_reg   <= pg_in;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg    <= status_next;
            page_addr_reg <= page_addr_next;
            count_reg     <= count_next;
            released_reg  <= released_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign page_addr     = page_addr_reg;
    assign count         = count_reg;
    assign page_released = released_reg;

endmodule

// ===== src/rpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rpa_checker.sv =====
// Port-level checks for the page allocator and the bind that attaches them.
module rpa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [rpa_pkg::STATUS_W-1:0]        status,
    input logic [rpa_pkg::ADDR_W-1:0]          page_addr,
    input logic signed [rpa_pkg::COUNT_W-1:0]  count,
    input logic                                page_released
);

    import rpa_pkg::*;

    // every accepted transaction yields its result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transaction produced no result");

    // no result without a matching transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && page_released) |-> (status == ST_OK && page_addr == '0))
        else $error("page released with bad status or nonzero address");

    a_oom_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OOM) |-> (page_addr == '0 && count == '0 && !page_released))
        else $error("out-of-memory result carries data");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .page_addr     (page_addr),
    .count         (count),
    .page_released (page_released)
);

// ===== verif/tb_refcounted_page_allocator.sv =====
// Self-checking testbench for the reference-counted page allocator.
module tb_refcounted_page_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import rpa_pkg::*;

    localparam int unsigned NUM_PAGES   = 32768;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam logic [ADDR_W-1:0] BASE_ADDR = 39'h0080000000;
    localparam logic [ADDR_W-1:0] MEM_END   = BASE_ADDR + (39'(NUM_PAGES) << PAGE_SHIFT);
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned TAIL_CYCLES  = 10;

    typedef struct {
        status_t            st;
        logic [ADDR_W-1:0]  paddr;
        logic [COUNT_W-1:0] cnt;
        logic               rel;
    } page_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   addr;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_data;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_addr;
    logic signed [COUNT_W-1:0] count;
    logic                page_released;

    // allocator shadow state
    logic [14:0]        freed_pages [NUM_PAGES];
    logic [COUNT_W-1:0] page_count [NUM_PAGES];
    int unsigned        freed_depth;
    int unsigned        fresh_mark;
    int unsigned        owned_floor;

    page_result_t       pending_results [$];
    logic [ADDR_W-1:0]  held_pages [$];
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;

    refcounted_page_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .BASE_ADDR  (BASE_ADDR),
        .PAGE_BYTES (PAGE_BYTES),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .addr          (addr),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .page_addr     (page_addr),
        .count         (count),
        .page_released (page_released)
    );

    always #6 clk = ~clk;

    function automatic logic [ADDR_W-1:0] page_base(input int unsigned pg);
        return BASE_ADDR + (39'(pg) << PAGE_SHIFT);
    endfunction

    task automatic apply_page_action(input logic [ACTION_W-1:0] act,
                                     input logic [ADDR_W-1:0] ad,
                                     output page_result_t res);
        logic        in_mem;
        int unsigned pg;
        in_mem = ad >= BASE_ADDR && ad < MEM_END;
        pg     = 32'((ad - BASE_ADDR) >> PAGE_SHIFT) % NUM_PAGES;
        res    = '{ST_OK, '0, '0, 1'b0};
        case (act)
            ACT_ALLOC:
            begin
                if (freed_depth > 0)
                begin
                    freed_depth--;
                    pg = 32'(freed_pages[freed_depth]);
                end
                else if (fresh_mark > owned_floor)
                begin
                    fresh_mark--;
                    pg = fresh_mark;
                end
                else
                    res.st = ST_OOM;
                if (res.st == ST_OK)
                begin
                    page_count[pg] = COUNT_W'(1);
                    res.cnt        = COUNT_W'(1);
                    res.paddr      = page_base(pg);
                end
            end
            ACT_FREE:
            begin
                if (ad[PAGE_SHIFT-1:0] != '0 || !in_mem || pg < owned_floor)
                    res.st = ST_BADFREE;
                else
                begin
                    page_count[pg] = page_count[pg] - 1'b1;
                    res.cnt        = page_count[pg];
                    // zero or negative count releases the page
                    if (page_count[pg] == '0 || page_count[pg][COUNT_W-1])
                    begin
                        if (freed_depth < NUM_PAGES)
                        begin
                            freed_pages[freed_depth] = 15'(pg);
                            freed_depth++;
                            res.rel = 1'b1;
                        end
                        else
                            res.st = ST_FULL;
                    end
                end
            end
            ACT_INC, ACT_DEC, ACT_GET:
            begin
                if (!in_mem)
                begin
                    res.st  = ST_RANGE;
                    res.cnt = '1;
                end
                else
                begin
                    if (act == ACT_INC)
                        page_count[pg] = page_count[pg] + 1'b1;
                    else if (act == ACT_DEC)
                        page_count[pg] = page_count[pg] - 1'b1;
                    res.cnt = page_count[pg];
                end
            end
            default:
                res.st = ST_RANGE;
        endcase
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // start is left high after acceptance so back-to-back transactions need no extra step
    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] ad,
                           output page_result_t res);
        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        addr   <= ad;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_page_action(act, ad, res);
        pending_results.push_back(res);
        if (act == ACT_ALLOC && res.st == ST_OK)
        begin
            held_pages.push_back(res.paddr);
            if (held_pages.size() > 48)
                void'(held_pages.pop_front());
        end
    endtask

    task automatic idle_for(input int unsigned n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_floor(input logic [CFG_W-1:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        owned_floor = 32'(value);
    endtask

    function automatic logic [ADDR_W-1:0] random_addr();
        case ($urandom_range(0, 3))
            0: return ADDR_W'({$urandom, $urandom});
            1: return BASE_ADDR + 39'($urandom_range(0, (NUM_PAGES << PAGE_SHIFT) - 1));
            2: return page_base($urandom_range(0, NUM_PAGES - 1));
            default: return ($urandom_range(0, 1) ? BASE_ADDR : MEM_END)
                            + 39'($urandom_range(0, 2 * PAGE_BYTES)) - 39'(PAGE_BYTES);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] held_or_random(input bool_aligned);
        logic [ADDR_W-1:0] ad;
        if (held_pages.size() == 0 || $urandom_range(0, 9) < 3)
            return random_addr();
        ad = held_pages[$urandom_range(0, held_pages.size() - 1)];
        if (!bool_aligned)
            ad = ad + 39'($urandom_range(0, PAGE_BYTES - 1));
        return ad;
    endfunction

    task automatic test_directed();
        page_result_t r;
        send_op(ACT_GET, BASE_ADDR, r);
        send_op(ACT_ALLOC, '0, r);                      // first page comes off the watermark
        send_op(ACT_INC, page_base(NUM_PAGES - 1), r);
        send_op(ACT_DEC, page_base(NUM_PAGES - 1), r);
        send_op(ACT_FREE, page_base(NUM_PAGES - 1), r);
        send_op(ACT_ALLOC, '0, r);                      // pops the page just freed
        send_op(ACT_FREE, page_base(5), r);             // never handed out, still pushed
        send_op(ACT_ALLOC, '0, r);
        send_op(ACT_ALLOC, '0, r);
        send_op(ACT_FREE, BASE_ADDR + 39'd1, r);
        send_op(ACT_FREE, '0, r);
        send_op(ACT_FREE, MEM_END, r);
        send_op(ACT_FREE, '1, r);
        send_op(ACT_GET, MEM_END - 39'd1, r);
        send_op(ACT_GET, BASE_ADDR - 39'd1, r);
        send_op(ACT_INC, '1, r);
        send_op(ACT_DEC, '0, r);
        send_op(ACT_DEC, page_base(10) + 39'd123, r);   // goes negative
        send_op(ACT_GET, page_base(10) + 39'(PAGE_BYTES - 1), r);
        for (int a = ACT_GET + 1; a < (1 << ACTION_W); a++)
            send_op(ACTION_W'(a), random_addr(), r);
    endtask

    task automatic test_floor_and_oom();
        page_result_t r;
        write_floor(CFG_W'(NUM_PAGES));
        send_op(ACT_FREE, page_base(100), r);           // below the owned range
        send_op(ACT_INC, page_base(100), r);
        send_op(ACT_GET, page_base(100), r);
        while (freed_depth > 0)
            send_op(ACT_ALLOC, '0, r);
        send_op(ACT_ALLOC, '0, r);
        send_op(ACT_ALLOC, '0, r);
        write_floor(CFG_W'(fresh_mark - 3));
        repeat (4)
            send_op(ACT_ALLOC, '0, r);
        write_floor('0);
    endtask

    task automatic test_random();
        page_result_t        r;
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   ad;
        int unsigned         sel;
        bit                  gaps_on;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                gaps_on = 1'($urandom_range(0, 1));
            if (i == RANDOM_ITEMS / 2)
                write_floor(CFG_W'(fresh_mark - $urandom_range(0, 40)));
            sel = $urandom_range(0, 99);
            if (sel < 25)
            begin
                act = ACT_ALLOC;
                ad  = random_addr();
            end
            else if (sel < 50)
            begin
                act = ACT_FREE;
                ad  = held_or_random(1'b1);
            end
            else if (sel < 95)
            begin
                act = (sel < 65) ? ACT_INC : (sel < 80) ? ACT_DEC : ACT_GET;
                ad  = held_or_random(1'b0);
            end
            else
            begin
                act = ACTION_W'($urandom_range(ACT_GET + 1, (1 << ACTION_W) - 1));
                ad  = random_addr();
            end
            send_op(act, ad, r);
            // last part of the run goes back to back
            if (gaps_on && i < RANDOM_ITEMS - RANDOM_ITEMS / 5 && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 12));
        end
    endtask

    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf("result with nothing expected: st=%0d pa=%h cnt=%0d rel=%b",
                                       status, page_addr, count, page_released));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || page_addr !== want.paddr ||
                    count !== want.cnt || page_released !== want.rel)
                    log_mismatch($sformatf(
                        "exp st=%0d pa=%h cnt=%0d rel=%b, got st=%0d pa=%h cnt=%0d rel=%b",
                        want.st, want.paddr, $signed(want.cnt), want.rel,
                        status, page_addr, count, page_released));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = ACT_ALLOC;
        addr     = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        for (int unsigned i = 0; i < NUM_PAGES; i++)
        begin
            page_count[i]  = '0;
            freed_pages[i] = '0;
        end
        freed_depth = 0;
        fresh_mark  = NUM_PAGES;
        owned_floor = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // count table clear runs after reset
        @(posedge clk);
        while (busy)
            @(posedge clk);
        write_floor('0);

        test_directed();
        test_floor_and_oom();
        test_random();

        wait_quiet();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/rpa_pkg.sv
src/rpa_ram.sv
src/refcounted_page_allocator.sv
src/rpa_checker.sv
verif/tb_refcounted_page_allocator.sv
